// ===== hw/rtl/ile_pkg.sv =====
// Package for the indexed list engine: command, status and controller state codes.
// Used by the controller top level; depends on nothing else.
`default_nettype none
package ile_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_UPDATE = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SHIFT  = 2'd1,
		S_READ   = 2'd2,
		S_FINISH = 2'd3
	} state_t;

	localparam int unsigned POS_BITS   = 5;
	localparam int unsigned CMD_BITS   = 2;
	localparam int unsigned WORD_PORT  = 64;
	localparam int unsigned COUNT_PORT = 5;
	localparam int unsigned STAT_BITS  = 2;

endpackage
`default_nettype wire

// ===== hw/rtl/ile_cmd_if.sv =====
// Command channel of the indexed list engine: valid/ready plus the command payload.
// Depends on ile_pkg for the field widths.
`default_nettype none
interface ile_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [ile_pkg::CMD_BITS-1:0]   cmd;
	logic [ile_pkg::POS_BITS-1:0]   position;
	logic [ile_pkg::WORD_PORT-1:0]  data_word;

	modport source (output valid, cmd, position, data_word, input ready);
	modport sink (input valid, cmd, position, data_word, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ile_res_if.sv =====
// Result channel of the indexed list engine: valid/ready plus the result payload.
// Depends on ile_pkg for the field widths.
`default_nettype none
interface ile_res_if;
	logic                            valid;
	logic                            ready;
	logic [ile_pkg::WORD_PORT-1:0]   read_word;
	logic [ile_pkg::COUNT_PORT-1:0]  entry_count;
	logic [ile_pkg::STAT_BITS-1:0]   status;

	modport source (output valid, read_word, entry_count, status, input ready);
	modport sink (input valid, read_word, entry_count, status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ile_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
`default_nettype none
module ile_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_list_engine_unit.sv =====
// Indexed list engine top level: command decode, shift sequencer and result register.
// Depends on ile_pkg, ile_cmd_if, ile_res_if and ile_ram.
//
// Usage: each request on cmd_ch is one command (insert, remove, update or read)
// at a list position. Every request yields exactly one result on res_ch with the
// read word (zero unless a successful read), the entry count after the command
// and a status code. The list lives in one RAM of CAPACITY words.
// Timing: a request is taken only while the engine is idle. Update and failed
// commands go straight to the finish state; a read passes the read state. Insert
// and remove move every later entry by one slot through the single RAM read port
// and write port, one entry per cycle, in the shift state before finishing.
// The result sits in an output register; a new request is taken while it still
// waits to be taken. If the receiver stalls, a finished result is held inside
// until the output register frees, and no further request is taken meanwhile.
// Reset empties the list (count zero) and drops any pending result; the RAM
// needs no clearing since only written positions can be addressed.
`default_nettype none
module indexed_list_engine_unit #(
	parameter int unsigned CAPACITY  = 16,
	parameter int unsigned WORD_BITS = 64
) (
	input wire logic  clk,
	input wire logic  arst_n,
	ile_cmd_if.sink   cmd_ch,
	ile_res_if.source res_ch
);

	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > ile_pkg::POS_BITS) ? CW : ile_pkg::POS_BITS;

	ile_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    mv_q;
	logic [AW-1:0]    ptr_q;
	logic [AW-1:0]    pos_q;
	logic [AW-1:0]    dst_s1;
	logic             valid_s1;
	logic             is_ins_q;
	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] rd_q;
	ile_pkg::status_t status_q;

	logic                     res_valid_q;
	logic [WORD_BITS-1:0]     res_word_q;
	logic [CW-1:0]            res_count_q;
	ile_pkg::status_t         res_status_q;

	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	logic             in_fire, out_free, shift_done;
	ile_pkg::cmd_t    in_cmd;
	logic [CMPW-1:0]  pos_ext, cnt_ext;
	logic             in_range, ins_range, list_full;
	ile_pkg::status_t in_status;
	logic [AW-1:0]    pos_a;
	logic [WORD_BITS-1:0] in_word;

	assign in_cmd    = ile_pkg::cmd_t'(cmd_ch.cmd);
	assign pos_ext   = CMPW'(cmd_ch.position);
	assign cnt_ext   = CMPW'(count_q);
	assign in_range  = pos_ext < cnt_ext;
	assign ins_range = pos_ext <= cnt_ext;
	assign list_full = count_q == CW'(CAPACITY);
	assign pos_a     = AW'(pos_ext);
	assign in_word   = cmd_ch.data_word[WORD_BITS-1:0];
	assign in_fire   = cmd_ch.valid && cmd_ch.ready;
	assign out_free  = !res_valid_q || res_ch.ready;
	assign shift_done = (mv_q == '0) && !valid_s1;

	always_comb begin
		if (in_cmd == ile_pkg::CMD_INSERT) begin
			if (!ins_range) begin
				in_status = ile_pkg::ST_RANGE;
			end else if (list_full) begin
				in_status = ile_pkg::ST_FULL;
			end else begin
				in_status = ile_pkg::ST_OK;
			end
		end else if (!in_range) begin
			in_status = ile_pkg::ST_RANGE;
		end else begin
			in_status = ile_pkg::ST_OK;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ile_pkg::S_IDLE: begin
				if (in_fire) begin
					if (in_status != ile_pkg::ST_OK) begin
						state_d = ile_pkg::S_FINISH;
					end else begin
						case (in_cmd)
							ile_pkg::CMD_INSERT,
							ile_pkg::CMD_REMOVE: state_d = ile_pkg::S_SHIFT;
							ile_pkg::CMD_READ:   state_d = ile_pkg::S_READ;
							default:             state_d = ile_pkg::S_FINISH;
						endcase
					end
				end
			end
			ile_pkg::S_SHIFT: begin
				if (shift_done) begin
					state_d = ile_pkg::S_FINISH;
				end
			end
			ile_pkg::S_READ: state_d = ile_pkg::S_FINISH;
			ile_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = ile_pkg::S_IDLE;
				end
			end
			default: state_d = ile_pkg::S_IDLE;
		endcase
	end

	// Outputs: request ready and RAM port control.
	always_comb begin
		cmd_ch.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ile_pkg::S_IDLE: begin
				cmd_ch.ready = 1'b1;
				if (cmd_ch.valid && in_status == ile_pkg::ST_OK) begin
					if (in_cmd == ile_pkg::CMD_UPDATE) begin
						ram_we    = 1'b1;
						ram_waddr = pos_a;
						ram_wdata = in_word;
					end else if (in_cmd == ile_pkg::CMD_READ) begin
						ram_re    = 1'b1;
						ram_raddr = pos_a;
					end
				end
			end
			ile_pkg::S_SHIFT: begin
				if (mv_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = ptr_q;
				end
				// A moved word lands one slot away from where it was read last cycle;
				// the new word of an insert goes in once all moves are written.
				if (valid_s1) begin
					ram_we    = 1'b1;
					ram_waddr = dst_s1;
					ram_wdata = ram_rdata;
				end else if (mv_q == '0 && is_ins_q) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q;
					ram_wdata = word_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ile_pkg::S_IDLE;
			count_q     <= '0;
			mv_q        <= '0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ile_pkg::S_IDLE && in_fire) begin
				if (in_status == ile_pkg::ST_OK && in_cmd == ile_pkg::CMD_INSERT) begin
					count_q <= count_q + CW'(1);
					mv_q    <= count_q - CW'(pos_ext);
				end else if (in_status == ile_pkg::ST_OK && in_cmd == ile_pkg::CMD_REMOVE) begin
					count_q <= count_q - CW'(1);
					mv_q    <= count_q - CW'(1) - CW'(pos_ext);
				end else begin
					mv_q <= '0;
				end
			end else if (state_q == ile_pkg::S_SHIFT && mv_q != '0) begin
				mv_q <= mv_q - CW'(1);
			end
			valid_s1 <= (state_q == ile_pkg::S_SHIFT) && (mv_q != '0);
			if (state_q == ile_pkg::S_FINISH && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ile_pkg::S_IDLE && in_fire) begin
			is_ins_q <= in_cmd == ile_pkg::CMD_INSERT;
			pos_q    <= pos_a;
			word_q   <= in_word;
			status_q <= in_status;
			rd_q     <= '0;
			if (in_cmd == ile_pkg::CMD_INSERT) begin
				ptr_q <= AW'(count_q - CW'(1));
			end else begin
				ptr_q <= pos_a + AW'(1);
			end
		end else if (state_q == ile_pkg::S_SHIFT && mv_q != '0) begin
			ptr_q <= is_ins_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
		end
		if (state_q == ile_pkg::S_READ) begin
			rd_q <= ram_rdata;
		end
		dst_s1 <= is_ins_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
		if (state_q == ile_pkg::S_FINISH && out_free) begin
			res_word_q   <= rd_q;
			res_count_q  <= count_q;
			res_status_q <= status_q;
		end
	end

	assign res_ch.valid       = res_valid_q;
	assign res_ch.read_word   = ile_pkg::WORD_PORT'(res_word_q);
	assign res_ch.entry_count = ile_pkg::COUNT_PORT'(res_count_q);
	assign res_ch.status      = res_status_q;

	ile_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_moves_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 || mv_q != '0) |-> state_q == ile_pkg::S_SHIFT)
		else $error("shift pipeline busy outside the shift state");

	a_no_write_late: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ile_pkg::S_IDLE || state_q == ile_pkg::S_SHIFT))
		else $error("RAM write outside idle or shift");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && res_ch.status != ile_pkg::ST_OK) |-> res_ch.read_word == '0)
		else $error("failed command returned a nonzero word");

	a_count_held_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_status != ile_pkg::ST_OK) |=> $stable(count_q))
		else $error("failed command changed the entry count");

endmodule
`default_nettype wire

// ===== tb/sv/indexed_list_engine_unit_tb.sv =====
// Self-checking testbench for the indexed list engine: insert, remove, update and read
// requests against a behavioral list predictor, under random idling on both channels.
// Depends on ile_pkg, ile_cmd_if, ile_res_if and indexed_list_engine_unit.
`timescale 1ns / 100ps
`default_nettype none
module indexed_list_engine_unit_tb;

	localparam int LIST_DEPTH = 16;
	localparam int RANDOM_PER_PHASE = 232;

	typedef struct {
		ile_pkg::cmd_t op;
		logic [4:0]    pos;
		logic [63:0]   word;
	} list_request_t;

	typedef struct {
		logic [63:0]      read_word;
		logic [4:0]       entry_count;
		ile_pkg::status_t status;
	} list_reply_t;

	logic clk;
	logic arst_n;

	ile_cmd_if cmd_ch ();
	ile_res_if res_ch ();

	indexed_list_engine_unit #(
		.CAPACITY  (LIST_DEPTH),
		.WORD_BITS (64)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.res_ch (res_ch)
	);

	list_request_t command_backlog[$];
	list_reply_t   predicted_replies[$];
	list_request_t next_req;

	// Predictor state: the list contents and its length as seen after each accepted request.
	logic [63:0] list_words [0:LIST_DEPTH-1];
	int          list_len;

	// Length the list will have once everything queued so far has run; steers positions.
	int gen_len;

	int send_idle_pct;
	int recv_stall_pct;
	int mismatch_count;

	function automatic list_reply_t apply_list_command(ile_pkg::cmd_t op, logic [4:0] pos,
			logic [63:0] word);
		list_reply_t r;
		int i;
		r.read_word = '0;
		r.status = ile_pkg::ST_OK;
		if (op == ile_pkg::CMD_INSERT) begin
			if (pos > list_len) begin
				r.status = ile_pkg::ST_RANGE;
			end else if (list_len >= LIST_DEPTH) begin
				r.status = ile_pkg::ST_FULL;
			end else begin
				for (i = list_len; i > pos; i--)
					list_words[i] = list_words[i-1];
				list_words[pos] = word;
				list_len++;
			end
		end else if (pos >= list_len) begin
			r.status = ile_pkg::ST_RANGE;
		end else if (op == ile_pkg::CMD_REMOVE) begin
			for (i = pos; i + 1 < list_len; i++)
				list_words[i] = list_words[i+1];
			list_len--;
		end else if (op == ile_pkg::CMD_UPDATE) begin
			list_words[pos] = word;
		end else begin
			r.read_word = list_words[pos];
		end
		r.entry_count = list_len[4:0];
		return r;
	endfunction

	task automatic queue_command(ile_pkg::cmd_t op, logic [4:0] pos, logic [63:0] word);
		list_request_t req;
		req.op = op;
		req.pos = pos;
		req.word = word;
		command_backlog.push_back(req);
		if (op == ile_pkg::CMD_INSERT && pos <= gen_len && gen_len < LIST_DEPTH)
			gen_len++;
		else if (op == ile_pkg::CMD_REMOVE && pos < gen_len)
			gen_len--;
	endtask

	task automatic queue_random_commands(int n);
		int k;
		int insert_bias;
		int roll;
		ile_pkg::cmd_t op;
		logic [4:0] pos;
		logic [63:0] word;
		insert_bias = 50;
		for (k = 0; k < n; k++) begin
			// Drift the mix every 32 requests so the list swings between empty and full.
			if (k % 32 == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						insert_bias = 20;
					end
					1: begin
						insert_bias = 45;
					end
					default: begin
						insert_bias = 75;
					end
				endcase
			end
			roll = $urandom_range(0, 99);
			if (roll < insert_bias) begin
				op = ile_pkg::CMD_INSERT;
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						op = ile_pkg::CMD_REMOVE;
					end
					1: begin
						op = ile_pkg::CMD_UPDATE;
					end
					default: begin
						op = ile_pkg::CMD_READ;
					end
				endcase
			end
			if ($urandom_range(0, 99) < 12)
				pos = 5'($urandom_range(0, 31));
			else if (op == ile_pkg::CMD_INSERT)
				pos = 5'($urandom_range(0, gen_len));
			else if (gen_len == 0)
				pos = '0;
			else
				pos = 5'($urandom_range(0, gen_len - 1));
			roll = $urandom_range(0, 99);
			if (roll < 8)
				word = '1;
			else if (roll < 16)
				word = '0;
			else
				word = {$urandom, $urandom};
			queue_command(op, pos, word);
		end
	endtask

	task automatic drain_all();
		do
			@(negedge clk);
		while (command_backlog.size() != 0 || cmd_ch.valid || predicted_replies.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Request driver: holds a request until it is taken, then maybe idles before the next.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.cmd <= ile_pkg::CMD_INSERT;
			cmd_ch.position <= '0;
			cmd_ch.data_word <= '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				predicted_replies.push_back(apply_list_command(
					ile_pkg::cmd_t'(cmd_ch.cmd), cmd_ch.position, cmd_ch.data_word));
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (command_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = command_backlog.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.cmd <= next_req.op;
					cmd_ch.position <= next_req.pos;
					cmd_ch.data_word <= next_req.word;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Reply checker: every taken reply must match the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (predicted_replies.size() == 0) begin
				$error("unexpected reply: read_word %h entry_count %0d status %0d",
					res_ch.read_word, res_ch.entry_count, res_ch.status);
				mismatch_count++;
			end else begin
				if (res_ch.read_word !== predicted_replies[0].read_word) begin
					$error("read_word: expected %h, actual %h",
						predicted_replies[0].read_word, res_ch.read_word);
					mismatch_count++;
				end
				if (res_ch.entry_count !== predicted_replies[0].entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
						predicted_replies[0].entry_count, res_ch.entry_count);
					mismatch_count++;
				end
				if (res_ch.status !== predicted_replies[0].status) begin
					$error("status: expected %0d, actual %0d",
						predicted_replies[0].status, res_ch.status);
					mismatch_count++;
				end
				void'(predicted_replies.pop_front());
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		list_len = 0;
		gen_len = 0;
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: every command on an empty list, out-of-range positions at both
		// field extremes, inserts at head, middle and tail, and removal of inner entries.
		queue_command(ile_pkg::CMD_READ, 5'd0, 64'd0);
		queue_command(ile_pkg::CMD_REMOVE, 5'd0, 64'd0);
		queue_command(ile_pkg::CMD_UPDATE, 5'd0, '1);
		queue_command(ile_pkg::CMD_INSERT, 5'd1, '1);
		queue_command(ile_pkg::CMD_INSERT, 5'd31, '1);
		queue_command(ile_pkg::CMD_INSERT, 5'd0, '1);
		queue_command(ile_pkg::CMD_INSERT, 5'd1, 64'd0);
		queue_command(ile_pkg::CMD_INSERT, 5'd1, 64'hA5A5_5A5A_0F0F_F0F0);
		queue_command(ile_pkg::CMD_INSERT, 5'd0, 64'h0123_4567_89AB_CDEF);
		queue_command(ile_pkg::CMD_READ, 5'd0, 64'd0);
		queue_command(ile_pkg::CMD_READ, 5'd1, 64'd0);
		queue_command(ile_pkg::CMD_READ, 5'd2, 64'd0);
		queue_command(ile_pkg::CMD_READ, 5'd3, 64'd0);
		queue_command(ile_pkg::CMD_READ, 5'd4, 64'd0);
		queue_command(ile_pkg::CMD_UPDATE, 5'd2, 64'h5A5A_A5A5_F0F0_0F0F);
		queue_command(ile_pkg::CMD_READ, 5'd2, '1);
		queue_command(ile_pkg::CMD_REMOVE, 5'd1, 64'd0);
		queue_command(ile_pkg::CMD_READ, 5'd1, 64'd0);
		queue_command(ile_pkg::CMD_REMOVE, 5'd31, 64'd0);
		queue_command(ile_pkg::CMD_UPDATE, 5'd3, '1);
		queue_command(ile_pkg::CMD_REMOVE, 5'd2, 64'd0);
		queue_command(ile_pkg::CMD_REMOVE, 5'd0, 64'd0);
		drain_all();

		queue_random_commands(RANDOM_PER_PHASE);
		drain_all();

		send_idle_pct = 61;
		queue_random_commands(RANDOM_PER_PHASE);
		drain_all();

		send_idle_pct = 0;
		recv_stall_pct = 61;
		queue_random_commands(RANDOM_PER_PHASE);
		drain_all();

		// The sender holds back here until every outstanding reply has been taken.
		send_idle_pct = 16;
		recv_stall_pct = 16;
		queue_random_commands(RANDOM_PER_PHASE / 2);
		drain_all();
		queue_random_commands(RANDOM_PER_PHASE / 2);
		drain_all();

		recv_stall_pct = 0;
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/ile_pkg.sv
hw/rtl/ile_cmd_if.sv
hw/rtl/ile_res_if.sv
hw/rtl/ile_ram.sv
hw/rtl/indexed_list_engine_unit.sv
tb/sv/indexed_list_engine_unit_tb.sv
